### hw/rtl/cgco_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cgco_pkg
// Shared types, widths and codes for the circle grid cell overlap block.
// ----------------------------------------------------------------------------
package cgco_pkg;

  // Grid and number format.
  localparam int MAX_CELLS_PER_ROW = 1024;
  localparam int FRAC_BITS         = 16;
  localparam int SHIFT_BITS        = 2 * FRAC_BITS;
  localparam int CELL_W            = $clog2(MAX_CELLS_PER_ROW);
  localparam int N_W               = $clog2(MAX_CELLS_PER_ROW + 1);
  localparam int INDEX_W           = 20;
  localparam int SEQ_W             = 4;

  // Datapath widths of the coordinate to cell mapping.
  localparam int COORD_W  = 32;
  localparam int SCALE_W  = 32;
  localparam int OFS_W    = 31;
  localparam int DIFF_W   = COORD_W + 2;
  localparam int MAG_W    = DIFF_W - 1;
  localparam int MAG_LO_W = (MAG_W + 1) / 2;
  localparam int MAG_HI_W = MAG_W - MAG_LO_W;
  localparam int PLO_W    = MAG_LO_W + SCALE_W;
  localparam int PHI_W    = MAG_HI_W + SCALE_W;
  localparam int PROD_W   = MAG_W + SCALE_W;
  localparam int Q_W      = PROD_W - SHIFT_BITS;

  // Results per circle and probe points.
  localparam int NRES   = 9;
  localparam int NPROBE = 8;
  localparam int NLANE  = 5;
  localparam int SEL_W  = $clog2(NRES);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANGE_LOW     = 3'd0,
    REG_CELL_SCALE    = 3'd1,
    REG_RADIUS        = 3'd2,
    REG_DIAG_OFFSET   = 3'd3,
    REG_CELLS_PER_ROW = 3'd4
  } cfg_reg_t;

  // Coordinate lanes: centre, plus and minus radius, plus and minus diagonal.
  typedef logic [2:0] lane_idx_t;
  localparam lane_idx_t LANE_C  = 3'd0;
  localparam lane_idx_t LANE_PR = 3'd1;
  localparam lane_idx_t LANE_MR = 3'd2;
  localparam lane_idx_t LANE_PD = 3'd3;
  localparam lane_idx_t LANE_MD = 3'd4;

  // Lane used for x and for y by each probe, in probe order.
  localparam lane_idx_t PROBE_XL [NPROBE] = '{
    LANE_PR, LANE_MR, LANE_C, LANE_C, LANE_PD, LANE_MD, LANE_PD, LANE_MD
  };
  localparam lane_idx_t PROBE_YL [NPROBE] = '{
    LANE_C, LANE_C, LANE_PR, LANE_MR, LANE_PD, LANE_PD, LANE_MD, LANE_MD
  };

  // Register stages ahead of the serializer, one load enable each.
  localparam int NSTAGE = 5;

  // Stage load enables of the mapping pipeline.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } pipe_en_t;

  // One mapped coordinate: low cell bits and range flags.
  typedef struct packed {
    logic [CELL_W-1:0] num;
    logic              below;
    logic              above;
  } lane_res_t;

  // All cells of one circle, slot 0 being the main cell.
  typedef struct packed {
    logic [NRES-1:0]              mask;
    logic                         outside;
    logic [NRES-1:0][CELL_W-1:0]  xs;
    logic [NRES-1:0][CELL_W-1:0]  ys;
    logic signed [COORD_W-1:0]    echo_x;
    logic signed [COORD_W-1:0]    echo_y;
  } run_t;

endpackage
`default_nettype wire

### hw/rtl/circle_grid_cell_overlap.sv
`default_nettype none
// An accepted circle passes the five mapping stages, the serializer's hold register and
// the output register before its first cell word shows on out_valid.
// The mapping stages take one circle per cycle unless the serializer holds them back;
// the serializer sends one word per cycle when out_ready allows, one per cell (1 to 9).
// Reset (synchronous, active low) clears the stage valid bits, the serializer and the
// configuration registers to their defaults.
// ----------------------------------------------------------------------------
// circle_grid_cell_overlap
// Maps a circle centre and its eight probe points to square-grid cells and
// streams the distinct cells on the grid, main cell first.
// ----------------------------------------------------------------------------
module circle_grid_cell_overlap
  import cgco_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // Configuration write port.
  input  wire logic                       cfg_wr_en,
  input  wire logic        [CFG_IDX_W-1:0] cfg_index,
  input  wire logic        [SCALE_W-1:0]  cfg_wr_data,
  // Circle input channel.
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic signed [COORD_W-1:0]  in_pos_x,
  input  wire logic signed [COORD_W-1:0]  in_pos_y,
  // Cell output channel.
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic             [CELL_W-1:0]   out_cell_x,
  output logic             [CELL_W-1:0]   out_cell_y,
  output logic             [INDEX_W-1:0]  out_cell_index,
  output logic                            out_main_outside,
  output logic             [SEQ_W-1:0]    out_seq_number,
  output logic                            out_last,
  output logic signed      [COORD_W-1:0]  out_echo_x,
  output logic signed      [COORD_W-1:0]  out_echo_y
);

  logic signed [COORD_W-1:0] range_low_r;
  logic        [SCALE_W-1:0] cell_scale_r;
  logic        [OFS_W-1:0]   radius_r, diag_r;
  logic        [N_W-1:0]     cpr_r;
  logic        [N_W-1:0]     n_cells;

  logic [NSTAGE-1:0]         v_r;
  logic [NSTAGE-1:0]         rdy;
  logic                      ser_ready;
  pipe_en_t                  en;

  logic signed [COORD_W-1:0] ofs [NLANE];
  lane_res_t                 xr [NLANE];
  lane_res_t                 yr [NLANE];
  logic signed [COORD_W-1:0] ex_r [NSTAGE-1];
  logic signed [COORD_W-1:0] ey_r [NSTAGE-1];
  run_t                      run;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r  <= '0;
      cell_scale_r <= SCALE_W'(65536);
      radius_r     <= '0;
      diag_r       <= '0;
      cpr_r        <= N_W'(16);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_RANGE_LOW:     range_low_r  <= cfg_wr_data;
        REG_CELL_SCALE:    cell_scale_r <= cfg_wr_data;
        REG_RADIUS:        radius_r     <= cfg_wr_data[OFS_W-1:0];
        REG_DIAG_OFFSET:   diag_r       <= cfg_wr_data[OFS_W-1:0];
        REG_CELLS_PER_ROW: cpr_r        <= cfg_wr_data[N_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Grid size in use, held within one and the maximum.
  always_comb begin
    if (cpr_r == '0) begin
      n_cells = N_W'(1);
    end else if (cpr_r > N_W'(MAX_CELLS_PER_ROW)) begin
      n_cells = N_W'(MAX_CELLS_PER_ROW);
    end else begin
      n_cells = cpr_r;
    end
  end

  // Stage readiness: a stage loads when empty or when the next one loads.
  always_comb begin
    rdy[NSTAGE-1] = !v_r[NSTAGE-1] || ser_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    en.s1 = rdy[0];
    en.s2 = rdy[1];
    en.s3 = rdy[2];
    en.s4 = rdy[3];
    en.s5 = rdy[4];
  end

  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Centre coordinates travel alongside the lanes.
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      ex_r[0] <= in_pos_x;
      ey_r[0] <= in_pos_y;
    end
    for (int k = 1; k < NSTAGE - 1; k++) begin
      if (rdy[k]) begin
        ex_r[k] <= ex_r[k-1];
        ey_r[k] <= ey_r[k-1];
      end
    end
  end

  // Signed offsets of the five lanes.
  always_comb begin
    ofs[LANE_C]  = '0;
    ofs[LANE_PR] = COORD_W'({1'b0, radius_r});
    ofs[LANE_MR] = -COORD_W'({1'b0, radius_r});
    ofs[LANE_PD] = COORD_W'({1'b0, diag_r});
    ofs[LANE_MD] = -COORD_W'({1'b0, diag_r});
  end

  for (genvar g = 0; g < NLANE; g++) begin : g_lane
    cgco_coord_lane u_x_lane (
      .clk        (clk),
      .en         (en),
      .pos        (in_pos_x),
      .ofs        (ofs[g]),
      .range_low  (range_low_r),
      .cell_scale (cell_scale_r),
      .n_cells    (n_cells),
      .res        (xr[g])
    );
    cgco_coord_lane u_y_lane (
      .clk        (clk),
      .en         (en),
      .pos        (in_pos_y),
      .ofs        (ofs[g]),
      .range_low  (range_low_r),
      .cell_scale (cell_scale_r),
      .n_cells    (n_cells),
      .res        (yr[g])
    );
  end

  cgco_dedup u_dedup (
    .clk     (clk),
    .en      (en),
    .xr      (xr),
    .yr      (yr),
    .n_cells (n_cells),
    .echo_x  (ex_r[NSTAGE-2]),
    .echo_y  (ey_r[NSTAGE-2]),
    .run     (run)
  );

  cgco_serializer u_serializer (
    .clk              (clk),
    .rst_n            (rst_n),
    .run_valid        (v_r[NSTAGE-1]),
    .run              (run),
    .run_ready        (ser_ready),
    .n_cells          (n_cells),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_cell_x       (out_cell_x),
    .out_cell_y       (out_cell_y),
    .out_cell_index   (out_cell_index),
    .out_main_outside (out_main_outside),
    .out_seq_number   (out_seq_number),
    .out_last         (out_last),
    .out_echo_x       (out_echo_x),
    .out_echo_y       (out_echo_y)
  );

endmodule
`default_nettype wire

### hw/rtl/cgco_coord_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cgco_coord_lane
// Four-stage mapping of one offset coordinate to its grid cell: difference
// and magnitude, split partial products, sum and shift, range check.
// ----------------------------------------------------------------------------
module cgco_coord_lane
  import cgco_pkg::*;
(
  input  wire logic                      clk,
  input  wire pipe_en_t                  en,
  input  wire logic signed [COORD_W-1:0] pos,
  input  wire logic signed [COORD_W-1:0] ofs,
  input  wire logic signed [COORD_W-1:0] range_low,
  input  wire logic        [SCALE_W-1:0] cell_scale,
  input  wire logic        [N_W-1:0]     n_cells,
  output lane_res_t                      res
);

  logic signed [DIFF_W-1:0] diff;
  logic [MAG_W-1:0]         mag_nxt;
  logic [MAG_W-1:0]         mag_r;
  logic                     neg1_r, neg2_r, neg3_r;
  logic [PLO_W-1:0]         plo_r;
  logic [PHI_W-1:0]         phi_r;
  logic [PROD_W-1:0]        sum;
  logic [Q_W-1:0]           q_r;
  lane_res_t                res_nxt;
  lane_res_t                res_r;

  // Stage 1: signed distance from the lower edge, split into sign and size.
  always_comb begin
    diff = {{2{pos[COORD_W-1]}}, pos} + {{2{ofs[COORD_W-1]}}, ofs}
         - {{2{range_low[COORD_W-1]}}, range_low};
    if (diff[DIFF_W-1]) begin
      mag_nxt = MAG_W'(-diff);
    end else begin
      mag_nxt = MAG_W'(diff);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      mag_r  <= mag_nxt;
      neg1_r <= diff[DIFF_W-1];
    end
  end

  // Stage 2: two partial products of the size with the scale.
  always_ff @(posedge clk) begin
    if (en.s2) begin
      plo_r  <= PLO_W'(mag_r[MAG_LO_W-1:0]) * PLO_W'(cell_scale);
      phi_r  <= PHI_W'(mag_r[MAG_W-1:MAG_LO_W]) * PHI_W'(cell_scale);
      neg2_r <= neg1_r;
    end
  end

  // Stage 3: full product, integer part kept.
  assign sum = PROD_W'(plo_r) + (PROD_W'(phi_r) << MAG_LO_W);

  always_ff @(posedge clk) begin
    if (en.s3) begin
      q_r    <= sum[PROD_W-1:SHIFT_BITS];
      neg3_r <= neg2_r;
    end
  end

  // Stage 4: a negative non-zero cell lies below the grid, q >= n above it.
  always_comb begin
    res_nxt.num   = q_r[CELL_W-1:0];
    res_nxt.below = neg3_r && (q_r != '0);
    res_nxt.above = q_r >= Q_W'(n_cells);
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

### hw/rtl/cgco_dedup.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cgco_dedup
// Clamps the main cell, drops probe cells off the grid or already seen and
// registers the run of cells for one circle.
// ----------------------------------------------------------------------------
module cgco_dedup
  import cgco_pkg::*;
(
  input  wire logic                      clk,
  input  wire pipe_en_t                  en,
  input  wire lane_res_t                 xr [NLANE],
  input  wire lane_res_t                 yr [NLANE],
  input  wire logic        [N_W-1:0]     n_cells,
  input  wire logic signed [COORD_W-1:0] echo_x,
  input  wire logic signed [COORD_W-1:0] echo_y,
  output run_t                           run
);

  logic [CELL_W-1:0] n_max;
  logic [CELL_W-1:0] mx, my;
  logic [CELL_W-1:0] px [NPROBE];
  logic [CELL_W-1:0] py [NPROBE];
  logic [NPROBE-1:0] inb;
  logic [NPROBE-1:0] keep;
  run_t              run_nxt;
  run_t              run_r;

  assign n_max = CELL_W'(n_cells - N_W'(1));

  // Main cell clamped into the grid.
  always_comb begin
    if (xr[LANE_C].below) begin
      mx = '0;
    end else if (xr[LANE_C].above) begin
      mx = n_max;
    end else begin
      mx = xr[LANE_C].num;
    end
    if (yr[LANE_C].below) begin
      my = '0;
    end else if (yr[LANE_C].above) begin
      my = n_max;
    end else begin
      my = yr[LANE_C].num;
    end
  end

  // Probe cells: kept when on the grid and unequal to the main cell and to
  // every earlier probe cell on the grid.
  always_comb begin
    for (int i = 0; i < NPROBE; i++) begin
      px[i]  = xr[PROBE_XL[i]].num;
      py[i]  = yr[PROBE_YL[i]].num;
      inb[i] = !xr[PROBE_XL[i]].below && !xr[PROBE_XL[i]].above
            && !yr[PROBE_YL[i]].below && !yr[PROBE_YL[i]].above;
    end
    for (int i = 0; i < NPROBE; i++) begin
      keep[i] = inb[i] && !((px[i] == mx) && (py[i] == my));
      for (int j = 0; j < NPROBE; j++) begin
        if ((j < i) && inb[j] && (px[j] == px[i]) && (py[j] == py[i])) begin
          keep[i] = 1'b0;
        end
      end
    end
  end

  // Assemble the run word.
  always_comb begin
    run_nxt.mask    = {keep, 1'b1};
    run_nxt.outside = xr[LANE_C].below || xr[LANE_C].above
                   || yr[LANE_C].below || yr[LANE_C].above;
    run_nxt.xs[0]   = mx;
    run_nxt.ys[0]   = my;
    for (int i = 0; i < NPROBE; i++) begin
      run_nxt.xs[i+1] = px[i];
      run_nxt.ys[i+1] = py[i];
    end
    run_nxt.echo_x  = echo_x;
    run_nxt.echo_y  = echo_y;
  end

  always_ff @(posedge clk) begin
    if (en.s5) begin
      run_r <= run_nxt;
    end
  end

  assign run = run_r;

endmodule
`default_nettype wire

### hw/rtl/cgco_serializer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cgco_serializer
// Holds the run of one circle and sends its cells, one word per cycle while
// out_ready allows, through the output register.
// ----------------------------------------------------------------------------
module cgco_serializer
  import cgco_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       run_valid,
  input  wire run_t                       run,
  output logic                            run_ready,
  input  wire logic        [N_W-1:0]      n_cells,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic             [CELL_W-1:0]   out_cell_x,
  output logic             [CELL_W-1:0]   out_cell_y,
  output logic             [INDEX_W-1:0]  out_cell_index,
  output logic                            out_main_outside,
  output logic             [SEQ_W-1:0]    out_seq_number,
  output logic                            out_last,
  output logic signed      [COORD_W-1:0]  out_echo_x,
  output logic signed      [COORD_W-1:0]  out_echo_y
);

  localparam int PROD_IW = CELL_W + N_W;

  run_t               hold_r;
  logic [NRES-1:0]    rem_r, rem_nxt, rem_rest;
  logic [SEQ_W-1:0]   seq_r, seq_nxt;
  logic [SEL_W-1:0]   sel;
  logic               emit;
  logic [CELL_W-1:0]  cx, cy;
  logic [PROD_IW-1:0] lin;
  logic               out_valid_r;
  logic [CELL_W-1:0]  cell_x_r, cell_y_r;
  logic [INDEX_W-1:0] cell_index_r;
  logic               outside_r, last_r;
  logic [SEQ_W-1:0]   seq_out_r;
  logic signed [COORD_W-1:0] echo_x_r, echo_y_r;

  // Lowest cell still to send.
  always_comb begin
    sel = '0;
    for (int k = NRES - 1; k >= 0; k--) begin
      if (rem_r[k]) begin
        sel = SEL_W'(k);
      end
    end
    rem_rest = rem_r & ~(NRES'(1) << sel);
  end

  assign emit      = (rem_r != '0) && (!out_valid_r || out_ready);
  assign run_ready = (rem_r == '0) || (emit && (rem_rest == '0));

  // Remaining mask and sequence count.
  always_comb begin
    rem_nxt = rem_r;
    seq_nxt = seq_r;
    if (emit) begin
      rem_nxt = rem_rest;
      seq_nxt = seq_r + SEQ_W'(1);
    end
    if (run_ready) begin
      rem_nxt = run_valid ? run.mask : '0;
      seq_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      seq_r <= '0;
    end else begin
      rem_r <= rem_nxt;
      seq_r <= seq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (run_ready && run_valid) begin
      hold_r <= run;
    end
  end

  // Linear cell number of the selected cell.
  always_comb begin
    cx  = hold_r.xs[sel];
    cy  = hold_r.ys[sel];
    lin = PROD_IW'(cy) * PROD_IW'(n_cells) + PROD_IW'(cx);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      cell_x_r     <= cx;
      cell_y_r     <= cy;
      cell_index_r <= lin[INDEX_W-1:0];
      outside_r    <= hold_r.outside;
      seq_out_r    <= seq_r + SEQ_W'(1);
      last_r       <= (rem_rest == '0);
      echo_x_r     <= hold_r.echo_x;
      echo_y_r     <= hold_r.echo_y;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cell_x       = cell_x_r;
  assign out_cell_y       = cell_y_r;
  assign out_cell_index   = cell_index_r;
  assign out_main_outside = outside_r;
  assign out_seq_number   = seq_out_r;
  assign out_last         = last_r;
  assign out_echo_x       = echo_x_r;
  assign out_echo_y       = echo_y_r;

endmodule
`default_nettype wire

### tb/circle_grid_cell_overlap_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circle_grid_cell_overlap_tb
// Self-checking bench for the circle grid cell overlap block. A table of
// directed circles is followed by random circles across several grid
// settings and idling phases. Every accepted circle is turned into the
// expected stream of cell words, and each word leaving the block is checked
// field by field against the oldest one waiting.
// ----------------------------------------------------------------------------
module circle_grid_cell_overlap_tb;
  import cgco_pkg::*;

  localparam int     CYCLE_LIMIT     = 200000;
  localparam int     LATENCY         = 7;
  localparam int     DIRECTED_N      = 22;
  localparam int     GRID_N          = 5;
  localparam int     PHASES          = 4;
  localparam int     GRIDS_PER_PHASE = 3;
  localparam int     ITEMS_PER_GRID  = 19;
  localparam int     MAX_REPORTS     = 10;
  localparam longint ONE_UNIT        = 64'h1_0000;

  // Register indexes past the end of the register list.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [COORD_W-1:0] range_low;
    logic [SCALE_W-1:0] cell_scale;
    logic [OFS_W-1:0]   radius;
    logic [OFS_W-1:0]   diag_offset;
    logic [N_W-1:0]     row_len;
  } grid_cfg_t;

  typedef struct packed {
    logic [CELL_W-1:0]  cell_x;
    logic [CELL_W-1:0]  cell_y;
    logic [INDEX_W-1:0] cell_index;
    logic               main_outside;
    logic [SEQ_W-1:0]   seq_number;
    logic               last;
    logic [COORD_W-1:0] echo_x;
    logic [COORD_W-1:0] echo_y;
  } cell_word_t;

  // One directed circle; the cell fields hold a typed-in answer when fixed is set.
  typedef struct packed {
    logic [2:0]         grid_id;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic               fixed;
    logic [CELL_W-1:0]  cell_x;
    logic [CELL_W-1:0]  cell_y;
    logic [INDEX_W-1:0] cell_index;
    logic               main_outside;
  } circle_row_t;

  localparam grid_cfg_t RESET_GRID = {32'h0, 32'h0001_0000, 31'h0, 31'h0, 11'd16};

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  cfg_wr_en   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = REG_RANGE_LOW;
  logic [SCALE_W-1:0]    cfg_wr_data = '0;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  logic [COORD_W-1:0]    in_pos_x    = '0;
  logic [COORD_W-1:0]    in_pos_y    = '0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  logic [CELL_W-1:0]     out_cell_x;
  logic [CELL_W-1:0]     out_cell_y;
  logic [INDEX_W-1:0]    out_cell_index;
  logic                  out_main_outside;
  logic [SEQ_W-1:0]      out_seq_number;
  logic                  out_last;
  logic [COORD_W-1:0]    out_echo_x;
  logic [COORD_W-1:0]    out_echo_y;

  grid_cfg_t   live_grid = RESET_GRID;
  cell_word_t  cells_due [$];
  grid_cfg_t   directed_grids [GRID_N];
  circle_row_t directed_rows [DIRECTED_N];
  longint      cell_span   = ONE_UNIT;
  int          send_gap_pct = 0;
  int          stall_pct    = 0;
  int          fail_count   = 0;
  int          words_seen   = 0;
  int          circles_sent = 0;
  int          grids_loaded = 0;
  int          cycle_count  = 0;

  circle_grid_cell_overlap i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_cell_x       (out_cell_x),
    .out_cell_y       (out_cell_y),
    .out_cell_index   (out_cell_index),
    .out_main_outside (out_main_outside),
    .out_seq_number   (out_seq_number),
    .out_last         (out_last),
    .out_echo_x       (out_echo_x),
    .out_echo_y       (out_echo_y)
  );

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Give up if the run hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d cell words outstanding.",
               cycle_count, cells_due.size());
      $display("FAIL circle_grid_cell_overlap");
      $finish;
    end
  end

  // The receiver stalls at random according to the current phase.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99, 0) >= stall_pct);
  end

  // Grid size actually in use: zero acts as one, oversize acts as the maximum.
  function automatic longint grid_size();
    longint n;
    n = longint'(live_grid.row_len);
    if (n < 1) n = 1;
    if (n > MAX_CELLS_PER_ROW) n = MAX_CELLS_PER_ROW;
    return n;
  endfunction

  // Cell number of one coordinate: exact wide product, truncated toward zero.
  function automatic longint map_coord(input longint coord);
    longint      offset;
    logic [63:0] mag;
    logic [95:0] prod;
    longint      q;
    offset = coord - longint'($signed(live_grid.range_low));
    mag    = (offset < 0) ? -offset : offset;
    prod   = {32'b0, mag} * {64'b0, live_grid.cell_scale};
    q      = longint'(prod[95:SHIFT_BITS]);
    return (offset < 0) ? -q : q;
  endfunction

  // Work out the cell words of one circle and queue them in order.
  function automatic void predict_cells(input logic [COORD_W-1:0] px,
                                        input logic [COORD_W-1:0] py);
    longint     n, cx_c, cy_c, off, sx, sy, x, y;
    longint     cx [NRES];
    longint     cy [NRES];
    logic       outside;
    int         count;
    bit         seen;
    cell_word_t w;
    n       = grid_size();
    cx_c    = longint'($signed(px));
    cy_c    = longint'($signed(py));
    outside = 1'b0;
    cx[0]   = map_coord(cx_c);
    cy[0]   = map_coord(cy_c);
    // The main cell is clamped onto the grid and flagged.
    if (cx[0] < 0) begin
      cx[0] = 0; outside = 1'b1;
    end else if (cx[0] > n - 1) begin
      cx[0] = n - 1; outside = 1'b1;
    end
    if (cy[0] < 0) begin
      cy[0] = 0; outside = 1'b1;
    end else if (cy[0] > n - 1) begin
      cy[0] = n - 1; outside = 1'b1;
    end
    count = 1;
    // Axis probes first, then the four diagonals; keep new on-grid cells only.
    for (int i = 0; i < NPROBE; i++) begin
      off = (i < 4) ? longint'(live_grid.radius) : longint'(live_grid.diag_offset);
      sx  = (i >= 2 && i < 4) ? 0 : ((i % 2) ? -1 : 1);
      sy  = (i < 2) ? 0 : (i < 4) ? ((i % 2) ? -1 : 1) : (((i / 2) % 2) ? -1 : 1);
      x   = map_coord(cx_c + sx * off);
      y   = map_coord(cy_c + sy * off);
      seen = 1'b0;
      for (int j = 0; j < count; j++)
        if (cx[j] == x && cy[j] == y) seen = 1'b1;
      if (x >= 0 && x < n && y >= 0 && y < n && !seen) begin
        cx[count] = x;
        cy[count] = y;
        count++;
      end
    end
    for (int k = 0; k < count; k++) begin
      w.cell_x       = CELL_W'(cx[k]);
      w.cell_y       = CELL_W'(cy[k]);
      w.cell_index   = INDEX_W'(cy[k] * n + cx[k]);
      w.main_outside = outside;
      w.seq_number   = SEQ_W'(k + 1);
      w.last         = (k == count - 1);
      w.echo_x       = px;
      w.echo_y       = py;
      cells_due.insert(cells_due.size(), w);
    end
  endfunction

  // A random grid: usually a sensible one sized around a cell width, else wild.
  function automatic grid_cfg_t random_grid(input bit wild);
    grid_cfg_t c;
    longint    span;
    if (wild) begin
      c = {$urandom, $urandom, 31'($urandom), 31'($urandom), 11'($urandom)};
      cell_span = ONE_UNIT;
      return c;
    end
    case ($urandom_range(6, 0))
      0:       c.row_len = N_W'($urandom_range(4, 1));
      1:       c.row_len = N_W'($urandom_range(16, 5));
      2:       c.row_len = N_W'($urandom_range(64, 17));
      3:       c.row_len = N_W'(MAX_CELLS_PER_ROW);
      4:       c.row_len = N_W'($urandom_range(MAX_CELLS_PER_ROW - 1, 65));
      5:       c.row_len = '0;
      default: c.row_len = N_W'($urandom_range(2047, MAX_CELLS_PER_ROW + 1));
    endcase
    span          = longint'($urandom_range(32'h0004_0000, 32'h0000_0100));
    c.cell_scale  = SCALE_W'((64'h1_0000_0000) / span);
    c.range_low   = COORD_W'($urandom_range(32'h0100_0000, 0)) - 32'h0080_0000;
    c.radius      = OFS_W'((span * $urandom_range(250, 0)) / 100);
    c.diag_offset = OFS_W'((longint'(c.radius) * 46341) >>> 16);
    cell_span     = span;
    return c;
  endfunction

  // A coordinate around the live grid, sometimes anywhere at all.
  function automatic logic [COORD_W-1:0] random_coord();
    longint reach;
    if ($urandom_range(4, 0) == 0) return $urandom;
    reach = (grid_size() + 2) * cell_span;
    return COORD_W'(longint'($signed(live_grid.range_low))
                    + longint'($urandom_range(32'(reach), 0)) - cell_span);
  endfunction

  // Write every register, then one index past the list, which must be ignored.
  task automatic load_grid(input grid_cfg_t c);
    for (int r = int'(REG_RANGE_LOW); r <= int'(REG_CELLS_PER_ROW); r++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= CFG_IDX_W'(r);
      case (cfg_reg_t'(r))
        REG_RANGE_LOW:   cfg_wr_data <= c.range_low;
        REG_CELL_SCALE:  cfg_wr_data <= c.cell_scale;
        REG_RADIUS:      cfg_wr_data <= {1'($urandom), c.radius};
        REG_DIAG_OFFSET: cfg_wr_data <= {1'($urandom), c.diag_offset};
        default:         cfg_wr_data <= {21'($urandom), c.row_len};
      endcase
      @(negedge clk);
    end
    cfg_index   <= CFG_IDX_W'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST));
    cfg_wr_data <= $urandom;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    live_grid = c;
    grids_loaded++;
  endtask

  // Hold the sender off until every queued cell word has arrived.
  task automatic drain_cells();
    in_valid <= 1'b0;
    do @(negedge clk); while (cells_due.size() != 0);
  endtask

  // Offer one circle and record what it should produce once it is taken.
  task automatic send_circle(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
                             input bit fixed, input cell_word_t fixed_word);
    while ($urandom_range(99, 0) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pos_x <= px;
    in_pos_y <= py;
    do @(posedge clk); while (!in_ready);
    if (fixed) cells_due.insert(cells_due.size(), fixed_word);
    else predict_cells(px, py);
    circles_sent++;
    @(negedge clk);
  endtask

  task automatic note_failure(input string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("Error at cycle %0d: %s", cycle_count, what);
  endtask

  // Check each cell word that leaves the block against the oldest expected one.
  always @(posedge clk) begin : check_words
    cell_word_t got, want;
    string      bad;
    if (rst_n && out_valid && out_ready) begin
      got = {out_cell_x, out_cell_y, out_cell_index, out_main_outside,
             out_seq_number, out_last, out_echo_x, out_echo_y};
      words_seen++;
      if (cells_due.size() == 0) begin
        note_failure($sformatf("unexpected cell word %p", got));
      end else begin
        want = cells_due.pop_front();
        bad  = "";
        if (got.cell_x       !== want.cell_x)       bad = {bad, " cell_x"};
        if (got.cell_y       !== want.cell_y)       bad = {bad, " cell_y"};
        if (got.cell_index   !== want.cell_index)   bad = {bad, " cell_index"};
        if (got.main_outside !== want.main_outside) bad = {bad, " main_outside"};
        if (got.seq_number   !== want.seq_number)   bad = {bad, " seq_number"};
        if (got.last         !== want.last)         bad = {bad, " last"};
        if (got.echo_x       !== want.echo_x)       bad = {bad, " echo_x"};
        if (got.echo_y       !== want.echo_y)       bad = {bad, " echo_y"};
        if (bad != "")
          note_failure($sformatf("mismatch in%s\n  expected %p\n  actual   %p",
                                 bad, want, got));
      end
    end
  end

  // Stimulus: directed table, then random circles over several idling phases.
  initial begin : stimulus
    circle_row_t row;
    cell_word_t  fixed_word;
    logic [2:0]  grid_now;
    int          pause_at;

    directed_grids = '{
      RESET_GRID,
      {32'h0000_0000, 32'h0001_0000, 31'h0001_0000, 31'h0000_C000, 11'd16},
      {32'h0000_0000, 32'h0001_0000, 31'h0001_0000, 31'h0000_B505, 11'd0},
      {32'h8000_0000, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 11'd2047},
      {32'h7FFF_FFFF, 32'h0000_0000, 31'h0000_0100, 31'h0000_0080, 11'd1}
    };
    // Reset grid rows carry their single word; later rows go through the predictor.
    directed_rows = '{
      {3'd0, 32'h0000_0000, 32'h0000_0000, 1'b1, 10'd0,  10'd0,  20'd0,   1'b0},
      {3'd0, 32'h000F_FFFF, 32'h000F_0000, 1'b1, 10'd15, 10'd15, 20'd255, 1'b0},
      {3'd0, 32'hFFFF_8000, 32'h0003_0000, 1'b1, 10'd0,  10'd3,  20'd48,  1'b0},
      {3'd0, 32'hFFFF_0000, 32'h0002_0000, 1'b1, 10'd0,  10'd2,  20'd32,  1'b1},
      {3'd0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 10'd15, 10'd0,  20'd15,  1'b1},
      {3'd0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 10'd0,  10'd15, 20'd240, 1'b1},
      {3'd0, 32'h0010_0000, 32'h0005_8000, 1'b1, 10'd15, 10'd5,  20'd95,  1'b1},
      {3'd1, 32'h0005_8000, 32'h0005_8000, 1'b0, 10'd0,  10'd0,  20'd0,   1'b0},
      {3'd1, 32'h0000_8000, 32'h0000_8000, 1'b0, 10'd0,  10'd0,  20'd0,   1'b0},
      {3'd1, 32'h000F_8000, 32'h000F_8000, 1'b0, 10'd0,  10'd0,  20'd0,   1'b0},
      {3'd1, 32'hFFFE_8000, 32'h0008_0000, 1'b0, 10'd0,  10'd0,  20'd0,   1'b0},
      {3'd1, 32'h0008_0000, 32'h0010_4000, 1'b0, 10'd0,  10'd0,  20'd0,   1'b0},
      {3'd1, 32'h0003_0000, 32'h0003_0000, 1'b0, 10'd0,  10'd0,  20'd0,   1'b0},
      {3'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, 10'd0,  10'd0,  20'd0,   1'b0},
      {3'd2, 32'h0000_8000, 32'h0000_8000, 1'b0, 10'd0,  10'd0,  20'd0,   1'b0},
      {3'd2, 32'h0001_8000, 32'h0000_0000, 1'b0, 10'd0,  10'd0,  20'd0,   1'b0},
      {3'd2, 32'h8000_0000, 32'h8000_0000, 1'b0, 10'd0,  10'd0,  20'd0,   1'b0},
      {3'd3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 10'd0,  10'd0,  20'd0,   1'b0},
      {3'd3, 32'h8000_0000, 32'h8000_0000, 1'b0, 10'd0,  10'd0,  20'd0,   1'b0},
      {3'd3, 32'h0000_0000, 32'h0000_0000, 1'b0, 10'd0,  10'd0,  20'd0,   1'b0},
      {3'd4, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 10'd0,  10'd0,  20'd0,   1'b0},
      {3'd4, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 10'd0,  10'd0,  20'd0,   1'b0}
    };

    // Hold the synchronous reset, then release it on a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed circles, starting on the reset grid.
    grid_now = 3'd0;
    for (int k = 0; k < DIRECTED_N; k++) begin
      row = directed_rows[k];
      if (row.grid_id != grid_now) begin
        drain_cells();
        load_grid(directed_grids[row.grid_id]);
        grid_now = row.grid_id;
      end
      fixed_word = {row.cell_x, row.cell_y, row.cell_index, row.main_outside,
                    SEQ_W'(1), 1'b1, row.pos_x, row.pos_y};
      send_circle(row.pos_x, row.pos_y, row.fixed, fixed_word);
    end

    // Random circles: free running, sender gaps, receiver stalls, then both.
    for (int p = 0; p < PHASES; p++) begin
      drain_cells();
      case (p)
        0:       begin send_gap_pct = 0;  stall_pct = 0;  end
        1:       begin send_gap_pct = 55; stall_pct = 0;  end
        2:       begin send_gap_pct = 0;  stall_pct = 55; end
        default: begin send_gap_pct = 30; stall_pct = 30; end
      endcase
      for (int g = 0; g < GRIDS_PER_PHASE; g++) begin
        drain_cells();
        load_grid(random_grid(g == 1));
        pause_at = $urandom_range(ITEMS_PER_GRID - 1, 1);
        for (int k = 0; k < ITEMS_PER_GRID; k++) begin
          if (k == pause_at) drain_cells();
          fixed_word = '0;
          send_circle(random_coord(), random_coord(), 1'b0, fixed_word);
        end
      end
    end

    // Let the last words out, then watch a little longer for strays.
    drain_cells();
    repeat (3 * LATENCY) @(negedge clk);

    $display("Checked %0d cell words from %0d circles over %0d register settings,",
             words_seen, circles_sent, grids_loaded);
    $display("with free running, sender gaps, receiver stalls and both together.");
    if (fail_count == 0 && cells_due.size() == 0) begin
      $display("PASS circle_grid_cell_overlap");
    end else begin
      $display("%0d failures, %0d cell words still expected.", fail_count, cells_due.size());
      $display("FAIL circle_grid_cell_overlap");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/cgco_pkg.sv
hw/rtl/cgco_coord_lane.sv
hw/rtl/cgco_dedup.sv
hw/rtl/cgco_serializer.sv
hw/rtl/circle_grid_cell_overlap.sv
tb/circle_grid_cell_overlap_tb.sv
